// File: hdl/frt_pkg.sv
`timescale 1ns / 1ps

package frt_pkg;

  // Default build parameters.
  localparam int CHANNELS_DEF   = 4;
  localparam int COUNT_BITS_DEF = 24;

  // Fixed field and register widths.
  localparam int MAX_CH     = 4;
  localparam int CHAN_W     = 2;
  localparam int LEVEL_W    = 4;
  localparam int PERIOD_W   = 16;
  localparam int IMP_W      = 16;
  localparam int SECS_W     = 7;
  localparam int RATE_W     = 32;
  localparam int TOTAL_W    = 48;
  localparam int FRAC_W     = 16;
  localparam int MUL60_W    = 6;
  localparam int DEN_W      = IMP_W + SECS_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Unit conversion constants.
  localparam int MS_PER_S    = 1000;
  localparam int SEC_PER_MIN = 60;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd5000;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PERIOD = 3'd0,
    REG_ENABLE = 3'd1,
    REG_IMP0   = 3'd2,
    REG_IMP1   = 3'd3,
    REG_IMP2   = 3'd4,
    REG_IMP3   = 3'd5
  } frt_reg_t;

  // Report sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SECS,
    ST_SCAN,
    ST_RATE,
    ST_ADD,
    ST_EMIT
  } frt_state_t;

  // Control from the sequencer to the pulse counter bank.
  typedef struct packed {
    logic              accept;
    logic              tick;
    logic              clear;
    logic [CHAN_W-1:0] clear_ch;
  } frt_pulse_ctl_t;

  // Width of the shared divider's dividend and quotient.
  function automatic int div_width(input int count_bits);
    int w;
    w = count_bits + MUL60_W + FRAC_W;
    return (w > TOTAL_W) ? w : TOTAL_W;
  endfunction

endpackage

// File: hdl/frt_div.sv
`timescale 1ns / 1ps

module frt_div #(
  parameter int NUM_W = 48,
  parameter int DEN_W = 23
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] acc_r, acc_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;

  // One restoring step: bring down the next dividend bit and try the subtract.
  assign trial = {rem_r, acc_r[NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign fits  = trial >= {1'b0, den_r};

  // Quotient bits shift in where dividend bits shift out.
  always_comb begin
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = busy_r && (cnt_r == CNT_W'(1));
    if (start) begin
      acc_nxt  = num;
      rem_nxt  = '0;
      den_nxt  = den;
      cnt_nxt  = CNT_W'(NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = {acc_r[NUM_W-2:0], fits};
      rem_nxt = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = acc_r;

endmodule

// File: hdl/frt_pulse.sv
`timescale 1ns / 1ps

module frt_pulse #(
  parameter int CHANNELS   = 4,
  parameter int COUNT_BITS = 24
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  frt_pkg::frt_pulse_ctl_t                     ctl,
  input  logic [frt_pkg::LEVEL_W-1:0]                 levels,
  input  logic [frt_pkg::MAX_CH-1:0]                  enable,
  input  logic [frt_pkg::PERIOD_W-1:0]                period,
  output logic                                        close,
  output logic [frt_pkg::MAX_CH-1:0][COUNT_BITS-1:0]  counts
);

  import frt_pkg::*;

  logic [LEVEL_W-1:0]                   prev_r, prev_nxt;
  logic [PERIOD_W-1:0]                  elapsed_r, elapsed_nxt;
  logic [CHANNELS-1:0][COUNT_BITS-1:0]  counts_r, counts_nxt;
  logic [LEVEL_W-1:0]                   falling;

  // A falling edge is a high level in the last transaction and low now.
  assign falling = prev_r & ~levels;

  // Window closes on a tick once the elapsed count has reached the period.
  assign close = ctl.accept && ctl.tick && (elapsed_r >= period);

  // Saturating pulse counters; the sequencer clears one once its total is updated.
  always_comb begin
    counts_nxt = counts_r;
    for (int i = 0; i < CHANNELS; i++) begin
      if (ctl.accept && falling[i] && enable[i] && (counts_r[i] != {COUNT_BITS{1'b1}})) begin
        counts_nxt[i] = counts_r[i] + COUNT_BITS'(1);
      end
      if (ctl.clear && (ctl.clear_ch == CHAN_W'(i))) begin
        counts_nxt[i] = '0;
      end
    end
  end

  // Level history and window timer.
  always_comb begin
    prev_nxt    = prev_r;
    elapsed_nxt = elapsed_r;
    if (ctl.accept) begin
      prev_nxt = levels;
      if (ctl.tick) begin
        elapsed_nxt = close ? '0 : elapsed_r + PERIOD_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r    <= '1;
      elapsed_r <= '0;
      counts_r  <= '0;
    end else begin
      prev_r    <= prev_nxt;
      elapsed_r <= elapsed_nxt;
      counts_r  <= counts_nxt;
    end
  end

  // Unbuilt channels read as zero.
  for (genvar g = 0; g < MAX_CH; g++) begin : g_cnt
    if (g < CHANNELS) begin : g_on
      assign counts[g] = counts_r[g];
    end else begin : g_off
      assign counts[g] = '0;
    end
  end

endmodule

// File: hdl/flow_meter_rate_totalizer.sv
`timescale 1ns / 1ps

// Channel   Handshake             Payload
// in        in_valid / in_ready   in_pin_levels, in_ms_tick
// out       out_valid / out_ready out_channel, out_rate_lpm, out_total_litres, out_last
// cfg       cfg_wr_en             cfg_index, cfg_wdata
//
// A transaction that does not close the window is taken without leaving idle.
// A closing transaction runs a bit-serial divider: first for whole seconds, then
// twice for each reporting channel (rate, then total increment), stepping past
// channels that do not report on the way (DIV_W = 48 by default), plus any wait
// on out_ready.
// in_ready is low while reports are computed; the last report may wait in the
// output register while new input transactions are taken.
// Reset is synchronous and active low; there is no clearing pass.

module flow_meter_rate_totalizer #(
  parameter int CHANNELS   = frt_pkg::CHANNELS_DEF,
  parameter int COUNT_BITS = frt_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [frt_pkg::LEVEL_W-1:0]       in_pin_levels,
  input  logic                              in_ms_tick,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [frt_pkg::CHAN_W-1:0]        out_channel,
  output logic [frt_pkg::RATE_W-1:0]        out_rate_lpm,
  output logic [frt_pkg::TOTAL_W-1:0]       out_total_litres,
  output logic                              out_last,
  input  logic                              cfg_wr_en,
  input  logic [frt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [frt_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  import frt_pkg::*;

  localparam int DIV_W   = div_width(COUNT_BITS);
  localparam int CNT60_W = COUNT_BITS + MUL60_W;

  // Configuration registers.
  logic [PERIOD_W-1:0]            period_r;
  logic [MAX_CH-1:0]              enable_r;
  logic [MAX_CH-1:0][IMP_W-1:0]   imp_r;

  // Sequencer and datapath registers.
  frt_state_t                     state_r, state_nxt;
  logic [CHAN_W-1:0]              ch_r, ch_nxt;
  logic [SECS_W-1:0]              secs_r;
  logic [RATE_W-1:0]              rate_r;
  logic [MAX_CH-1:0][TOTAL_W-1:0] total_r;
  logic                           out_valid_r;
  logic [CHAN_W-1:0]              out_channel_r;
  logic [RATE_W-1:0]              out_rate_r;
  logic [TOTAL_W-1:0]             out_total_r;
  logic                           out_last_r;

  // Internal nets.
  frt_pulse_ctl_t                 pulse_ctl;
  logic                           close;
  logic [MAX_CH-1:0][COUNT_BITS-1:0] counts;
  logic [MAX_CH-1:0]              qual;
  logic                           more;
  logic                           out_free;
  logic [COUNT_BITS-1:0]          cur_cnt;
  logic [IMP_W-1:0]               cur_imp;
  logic [CNT60_W-1:0]             cnt60;
  logic [DEN_W-1:0]               rate_den;
  logic                           div_start;
  logic [DIV_W-1:0]               div_num;
  logic [DEN_W-1:0]               div_den;
  logic                           div_done;
  logic [DIV_W-1:0]               div_quo;
  logic [RATE_W-1:0]              rate_val;
  logic [TOTAL_W:0]               total_sum;
  logic [TOTAL_W-1:0]             total_sat;

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RESET;
      enable_r <= '0;
      imp_r    <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_PERIOD: period_r <= cfg_wdata[PERIOD_W-1:0];
        REG_ENABLE: enable_r <= cfg_wdata[MAX_CH-1:0];
        REG_IMP0, REG_IMP1, REG_IMP2, REG_IMP3: begin
          imp_r[CHAN_W'(cfg_index - REG_IMP0)] <= cfg_wdata[IMP_W-1:0];
        end
        default: ;
      endcase
    end
  end

  frt_pulse #(
    .CHANNELS   (CHANNELS),
    .COUNT_BITS (COUNT_BITS)
  ) u_pulse (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (pulse_ctl),
    .levels (in_pin_levels),
    .enable (enable_r),
    .period (period_r),
    .close  (close),
    .counts (counts)
  );

  frt_div #(
    .NUM_W (DIV_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Channels that report, and whether one remains after the current one.
  always_comb begin
    more = 1'b0;
    for (int i = 0; i < MAX_CH; i++) begin
      qual[i] = (i < CHANNELS) && enable_r[i] && (imp_r[i] != '0);
      if ((CHAN_W'(i) > ch_r) && qual[i]) begin
        more = 1'b1;
      end
    end
  end

  // Operands of the current channel.
  assign cur_cnt  = counts[ch_r];
  assign cur_imp  = imp_r[ch_r];
  assign cnt60    = CNT60_W'(cur_cnt) * CNT60_W'(SEC_PER_MIN);
  assign rate_den = DEN_W'(cur_imp) * DEN_W'(secs_r);
  assign out_free = !out_valid_r || out_ready;

  // Rate saturates to all ones; a window under one second has no divisor.
  always_comb begin
    if (secs_r == '0) begin
      rate_val = (cur_cnt != '0) ? '1 : '0;
    end else if (|div_quo[DIV_W-1:RATE_W]) begin
      rate_val = '1;
    end else begin
      rate_val = div_quo[RATE_W-1:0];
    end
  end

  // Saturating totalizer update.
  assign total_sum = {1'b0, total_r[ch_r]} + {1'b0, div_quo[TOTAL_W-1:0]};
  assign total_sat = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];

  // Next state of the report sequencer.
  always_comb begin
    state_nxt = state_r;
    ch_nxt    = ch_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && close) begin
          state_nxt = ST_SECS;
          ch_nxt    = '0;
        end
      end
      ST_SECS: begin
        if (div_done) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (qual[ch_r]) begin
          state_nxt = ST_RATE;
        end else if (ch_r == CHAN_W'(CHANNELS - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          ch_nxt = ch_r + CHAN_W'(1);
        end
      end
      ST_RATE: begin
        if (div_done) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        if (div_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          if (more) begin
            state_nxt = ST_SCAN;
            ch_nxt    = ch_r + CHAN_W'(1);
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs: handshake, counter control and divider operands.
  always_comb begin
    in_ready           = 1'b0;
    pulse_ctl.accept   = 1'b0;
    pulse_ctl.tick     = in_ms_tick;
    pulse_ctl.clear    = 1'b0;
    pulse_ctl.clear_ch = ch_r;
    div_start          = 1'b0;
    div_num            = DIV_W'(period_r);
    div_den            = DEN_W'(MS_PER_S);
    case (state_r)
      ST_IDLE: begin
        in_ready         = 1'b1;
        pulse_ctl.accept = in_valid;
        div_start        = in_valid && close;
      end
      ST_SCAN: begin
        div_start = qual[ch_r];
        div_num   = DIV_W'({cnt60, {FRAC_W{1'b0}}});
        div_den   = rate_den;
      end
      ST_RATE: begin
        div_start = div_done;
        div_num   = DIV_W'({cur_cnt, {FRAC_W{1'b0}}});
        div_den   = DEN_W'(cur_imp);
      end
      ST_ADD: begin
        pulse_ctl.clear = div_done;
      end
      default: ;
    endcase
  end

  // Control registers and totals.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ch_r        <= '0;
      out_valid_r <= 1'b0;
      total_r     <= '0;
    end else begin
      state_r <= state_nxt;
      ch_r    <= ch_nxt;
      if ((state_r == ST_ADD) && div_done) begin
        total_r[ch_r] <= total_sat;
      end
      if ((state_r == ST_EMIT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if ((state_r == ST_SECS) && div_done) begin
      secs_r <= div_quo[SECS_W-1:0];
    end
    if ((state_r == ST_RATE) && div_done) begin
      rate_r <= rate_val;
    end
    if ((state_r == ST_EMIT) && out_free) begin
      out_channel_r <= ch_r;
      out_rate_r    <= rate_r;
      out_total_r   <= total_r[ch_r];
      out_last_r    <= !more;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_channel      = out_channel_r;
  assign out_rate_lpm     = out_rate_r;
  assign out_total_litres = out_total_r;
  assign out_last         = out_last_r;

endmodule

// File: hdl/frt_checker.sv
`timescale 1ns / 1ps

module frt_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          in_ms_tick,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [frt_pkg::CHAN_W-1:0]    out_channel,
  input logic [frt_pkg::RATE_W-1:0]    out_rate_lpm,
  input logic [frt_pkg::TOTAL_W-1:0]   out_total_litres,
  input logic                          out_last
);

  import frt_pkg::*;

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // A stalled report holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_channel) &&
      $stable(out_rate_lpm) && $stable(out_total_litres) && $stable(out_last))
    else $error("stalled report changed");

  // A transaction without a tick never closes a window.
  a_no_tick_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_ms_tick |=> in_ready)
    else $error("input blocked after a transaction without tick");

  // Input is taken only once every report but the last has left.
  a_block_mid_window: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input taken while a window report is pending");

  // The highest channel always closes its window.
  a_top_channel_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_channel == CHAN_W'(MAX_CH - 1)) |-> out_last)
    else $error("highest channel report not marked last");

endmodule

bind flow_meter_rate_totalizer frt_checker u_frt_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .in_ms_tick       (in_ms_tick),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_channel      (out_channel),
  .out_rate_lpm     (out_rate_lpm),
  .out_total_litres (out_total_litres),
  .out_last         (out_last)
);
